@@ sv/psi_pkg.sv @@
// Shared types, constants and controller/datapath signal groups for the Simpson integrator.
package psi_pkg;

    localparam int DATA_W    = 32;
    localparam int PAIR_W    = 16;
    localparam int SPAN_W    = 17;          // holds 2n and the sample index
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W     = 34;          // signed operand width of the shared multiplier
    localparam int PROD_W    = 2 * MUL_W;
    localparam int TOTAL_W   = 52;          // weighted sum over up to 2^17-1 samples
    localparam int BIG_W     = TOTAL_W + DATA_W;
    localparam int QUO_W     = DATA_W + 1;  // dividend of the step divider
    localparam int DIVR_W    = SPAN_W;      // divisor width of the step divider

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIRS = 2'd2;

    localparam logic signed [DATA_W-1:0] LOWER_RESET = 32'sd0;
    localparam logic signed [DATA_W-1:0] UPPER_RESET = 32'sd65536;
    localparam logic [PAIR_W-1:0]        PAIRS_RESET = 16'd1;

    localparam logic signed [PROD_W-1:0] Q16_HALF    = 68'sd32768;
    localparam logic [BIG_W-1:0]         SCALE_HALF  = 84'd98304;   // half of 3 * 2^16
    localparam logic [DATA_W:0]          RECIP3      = 33'h1_5555_5556; // ceil(2^34 / 3)
    localparam int                       RECIP3_SHIFT = 34;
    localparam logic signed [DATA_W-1:0] SAT_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN     = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_value;
        logic                     is_constant_term;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] integral;
        logic                     overflow;
    } out_t;

    typedef struct packed {
        logic load;
        logic init;
        logic div_step;
        logic set_step;
        logic eval_begin;
        logic mul_horner;
        logic horner_add;
        logic accumulate;
        logic advance;
        logic sc_lo;
        logic sc_hi;
        logic sc_sum;
        logic sc_third;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic count_zero;
        logic horner_last;
        logic sample_last;
    } stat_t;

endpackage

@@ sv/psi_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module psi_divider
    import psi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [QUO_W-1:0]   dividend,
    input  logic [DIVR_W-1:0]  divisor,
    output logic [QUO_W-1:0]   quotient,
    output logic               done
);

    localparam int CNT_W = $clog2(QUO_W);

    logic [DIVR_W:0]    rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [DIVR_W-1:0]  dvr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [DIVR_W+1:0]  trial;
    logic [DIVR_W+1:0]  shifted;

    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign trial   = shifted - {2'b00, dvr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvr_reg  <= '0;
        end
        else if (go)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= dividend;
            dvr_reg  <= divisor;
        end
        else if (run_reg)
        begin
            if (!trial[DIVR_W+1])
            begin
                rem_reg <= trial[DIVR_W:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIVR_W:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ sv/psi_datapath.sv @@
// Datapath: coefficient store, Horner evaluator, weighted sums and final scaling.
module psi_datapath
    import psi_pkg::*;
#(
    parameter int MAX_DEGREE = 15
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 st,
    input  in_t                   item,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data,
    output out_t                  result
);

    localparam int CW = $clog2(MAX_DEGREE + 1);
    localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

    logic signed [DATA_W-1:0] store_reg [MAX_DEGREE];

    logic signed [DATA_W-1:0]  lower_reg, upper_reg;
    logic [PAIR_W-1:0]         pairs_reg;
    logic [CW-1:0]             count_reg, k_reg;
    logic signed [DATA_W-1:0]  cst_reg, step_reg, pos_reg, acc_reg;
    logic [SPAN_W-1:0]         idx_reg, last_reg;
    logic                      diff_neg_reg, neg_reg, ov_reg, yhi_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic [BIG_W-1:0]          big_reg;
    out_t                      result_reg;

    logic signed [DATA_W:0]    diff;
    logic [DATA_W:0]           diff_mag;
    logic [PAIR_W-1:0]         pairs_eff;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [TOTAL_W-1:0]        mt;
    logic [DATA_W-1:0]         mh;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [49:0]        hsum;
    logic signed [DATA_W-1:0]  addend, hsat;
    logic                      hovf;
    logic signed [TOTAL_W-1:0] fx;
    logic [SPAN_W-1:0]         idx_inc;
    logic [QUO_W-1:0]          quo;
    logic [DATA_W-1:0]         third_q;
    logic                      div_done, fovf;
    logic signed [DATA_W-1:0]  fval;

    assign diff      = $signed({upper_reg[DATA_W-1], upper_reg})
                       - $signed({lower_reg[DATA_W-1], lower_reg});
    assign diff_mag  = diff[DATA_W] ? (DATA_W+1)'(0) - diff : diff;
    assign pairs_eff = (pairs_reg == '0) ? PAIR_W'(1) : pairs_reg;

    assign mt = total_reg[TOTAL_W-1] ? TOTAL_W'(0) - total_reg : total_reg;
    assign mh = step_reg[DATA_W-1] ? DATA_W'(0) - step_reg : step_reg;

    // multiplier operand selection: Horner uses signed Q16.16, scaling unsigned halves,
    // the divide by three a reciprocal of the rounded sum
    always_comb
    begin
        if (cmd.sc_lo)
        begin
            mul_a = $signed(MUL_W'(mt[DATA_W-1:0]));
            mul_b = $signed(MUL_W'(mh));
        end
        else if (cmd.sc_hi)
        begin
            mul_a = $signed(MUL_W'(mt[TOTAL_W-1:DATA_W]));
            mul_b = $signed(MUL_W'(mh));
        end
        else if (cmd.sc_third)
        begin
            mul_a = $signed(MUL_W'(big_reg[DATA_W+16:16]));
            mul_b = $signed(MUL_W'(RECIP3));
        end
        else
        begin
            mul_a = MUL_W'(acc_reg);
            mul_b = MUL_W'(pos_reg);
        end
    end
    assign mul_p = mul_a * mul_b;

    assign rounded = (prod_reg + Q16_HALF) >>> 16;
    assign addend  = (k_reg == count_reg) ? cst_reg : store_reg[k_reg[IW-1:0]];
    assign hsum    = rounded[49:0] + 50'(addend);
    assign hovf    = (hsum > 50'(SAT_MAX)) || (hsum < 50'(SAT_MIN));
    assign hsat    = (hsum > 50'(SAT_MAX)) ? SAT_MAX :
                     (hsum < 50'(SAT_MIN)) ? SAT_MIN : hsum[DATA_W-1:0];

    // endpoints weigh 1, odd samples 4, even samples 2
    always_comb
    begin
        fx = TOTAL_W'(acc_reg);
        if (idx_reg == '0 || idx_reg == last_reg)
            fx = TOTAL_W'(acc_reg);
        else if (idx_reg[0])
            fx = TOTAL_W'(acc_reg) <<< 2;
        else
            fx = TOTAL_W'(acc_reg) <<< 1;
    end
    assign idx_inc = idx_reg + 1'b1;

    psi_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_step),
        .dividend (diff_mag),
        .divisor  ({pairs_eff, 1'b0}),
        .quotient (quo),
        .done     (div_done)
    );

    // exact for every rounded sum below 2^33; anything larger saturates anyway
    assign third_q = prod_reg[RECIP3_SHIFT+DATA_W-1:RECIP3_SHIFT];
    assign fovf = yhi_reg || (third_q[DATA_W-1] && (!neg_reg || |third_q[DATA_W-2:0]));
    assign fval = fovf ? (neg_reg ? SAT_MIN : SAT_MAX) :
                  neg_reg ? DATA_W'(0) - third_q : third_q;

    always_ff @(posedge clk)
    begin
        if (cmd.load && count_reg < CW'(MAX_DEGREE))
            store_reg[count_reg[IW-1:0]] <= item.coef_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg    <= LOWER_RESET;
            upper_reg    <= UPPER_RESET;
            pairs_reg    <= PAIRS_RESET;
            count_reg    <= '0;
            k_reg        <= '0;
            idx_reg      <= '0;
            last_reg     <= '0;
            cst_reg      <= '0;
            step_reg     <= '0;
            pos_reg      <= '0;
            acc_reg      <= '0;
            diff_neg_reg <= 1'b0;
            neg_reg      <= 1'b0;
            ov_reg       <= 1'b0;
            yhi_reg      <= 1'b0;
            prod_reg     <= '0;
            total_reg    <= '0;
            big_reg      <= '0;
            result_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_LOWER: lower_reg <= $signed(cfg_data);
                    CFG_UPPER: upper_reg <= $signed(cfg_data);
                    CFG_PAIRS: pairs_reg <= cfg_data[PAIR_W-1:0];
                    default:   ;
                endcase
            end
            if (cmd.load && count_reg < CW'(MAX_DEGREE))
                count_reg <= count_reg + 1'b1;
            if (cmd.init)
            begin
                cst_reg      <= item.coef_value;
                last_reg     <= {pairs_eff, 1'b0};
                diff_neg_reg <= diff[DATA_W];
                pos_reg      <= lower_reg;
                idx_reg      <= '0;
                total_reg    <= '0;
                ov_reg       <= 1'b0;
            end
            if (cmd.set_step)
                step_reg <= diff_neg_reg ? DATA_W'(0) - quo[DATA_W-1:0] : quo[DATA_W-1:0];
            if (cmd.eval_begin)
            begin
                acc_reg <= (count_reg == '0) ? cst_reg : store_reg[0];
                k_reg   <= CW'(1);
            end
            if (cmd.mul_horner || cmd.sc_lo || cmd.sc_hi || cmd.sc_third)
                prod_reg <= mul_p;
            if (cmd.horner_add)
            begin
                acc_reg <= hsat;
                if (hovf)
                    ov_reg <= 1'b1;
                if (k_reg != count_reg)
                    k_reg <= k_reg + 1'b1;
            end
            if (cmd.accumulate)
                total_reg <= total_reg + fx;
            if (cmd.advance)
            begin
                idx_reg <= idx_inc;
                pos_reg <= (idx_inc == last_reg) ? upper_reg : pos_reg + step_reg;
            end
            if (cmd.sc_lo)
                neg_reg <= total_reg[TOTAL_W-1] != step_reg[DATA_W-1];
            if (cmd.sc_hi)
                big_reg <= BIG_W'(prod_reg[2*DATA_W-1:0]) + SCALE_HALF;
            if (cmd.sc_sum)
                big_reg <= big_reg + {prod_reg[BIG_W-DATA_W-1:0], {DATA_W{1'b0}}};
            if (cmd.sc_third)
                yhi_reg <= |big_reg[BIG_W-1:DATA_W+17];
            if (cmd.finish)
            begin
                result_reg.integral <= fval;
                result_reg.overflow <= ov_reg | fovf;
                count_reg           <= '0;
            end
        end
    end

    assign st.div_done    = div_done;
    assign st.count_zero  = (count_reg == '0);
    assign st.horner_last = (k_reg == count_reg);
    assign st.sample_last = (idx_reg == last_reg);
    assign result         = result_reg;

endmodule

@@ sv/psi_controller.sv @@
// Controller state machine that sequences loads, the sample sweep and the final scaling.
module psi_controller
    import psi_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  is_const,
    input  stat_t st,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    typedef enum logic [3:0] {
        S_IDLE, S_STEP_GO, S_STEP_WAIT, S_SAMPLE, S_MUL, S_ADD, S_ACCUM,
        S_SC_LO, S_SC_HI, S_SC_SUM, S_SC_THIRD, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = !is_const;
                    cmd.init = is_const;
                    if (is_const)
                        state_next = S_STEP_GO;
                end
            end
            S_STEP_GO:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_STEP_WAIT;
            end
            S_STEP_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.set_step = 1'b1;
                    state_next   = S_SAMPLE;
                end
            end
            S_SAMPLE:
            begin
                cmd.eval_begin = 1'b1;
                state_next     = st.count_zero ? S_ACCUM : S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_horner = 1'b1;
                state_next     = S_ADD;
            end
            S_ADD:
            begin
                cmd.horner_add = 1'b1;
                state_next     = st.horner_last ? S_ACCUM : S_MUL;
            end
            S_ACCUM:
            begin
                cmd.accumulate = 1'b1;
                cmd.advance    = !st.sample_last;
                state_next     = st.sample_last ? S_SC_LO : S_SAMPLE;
            end
            S_SC_LO:
            begin
                cmd.sc_lo  = 1'b1;
                state_next = S_SC_HI;
            end
            S_SC_HI:
            begin
                cmd.sc_hi  = 1'b1;
                state_next = S_SC_SUM;
            end
            S_SC_SUM:
            begin
                cmd.sc_sum = 1'b1;
                state_next = S_SC_THIRD;
            end
            S_SC_THIRD:
            begin
                cmd.sc_third = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINISH);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

@@ sv/polynomial_simpson_integrator.sv @@
// Top level of the polynomial integrator using the composite Simpson one-third rule.
//
// A transaction carries one Q16.16 coefficient, highest power first, and is taken at
// any edge with start high and busy low. Ordinary coefficients leave busy low; up to
// MAX_DEGREE are kept, later ones are dropped. The transaction flagged as the
// constant term closes the polynomial and raises busy while the integral over
// [lower_bound, upper_bound] is formed from 2n+1 samples. One shared 34x34
// multiplier and one bit-serial divider set the timing: busy stays high through the
// step division, the sample sweep and the final scaling, where the divide by three
// is a reciprocal multiply. The result appears on result for exactly one cycle with
// done high, as busy falls; the receiver cannot hold it off, so capture it then. Write
// configuration only while busy is low.
module polynomial_simpson_integrator
    import psi_pkg::*;
#(
    parameter int MAX_DEGREE = 15
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_t                   item,
    output logic                  done,
    output out_t                  result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data
);

    cmd_t  cmd;
    stat_t st;

    // sequence the sweep; the datapath only acts on commands
    psi_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .is_const (item.is_constant_term),
        .st       (st),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    // hold coefficients, bounds and sums; evaluate and scale
    psi_datapath #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

@@ sv/psi_checker.sv @@
// Port-level checker for the integrator and its bind to the top level.
module psi_checker
    import psi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  in_t  item,
    input  logic done
);

    // a result only appears as the block returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    // a coefficient load never occupies the block
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.is_constant_term) |=> (!busy && !done))
        else $error("coefficient load raised busy or done");

    // the constant term always starts an integration
    a_const_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.is_constant_term) |=> busy)
        else $error("constant term did not start integration");

    // one result per integration
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

endmodule

bind polynomial_simpson_integrator psi_checker u_psi_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done)
);

@@ verif/tb_polynomial_simpson_integrator.sv @@
// Self-checking testbench for the polynomial Simpson one-third rule integrator.
module tb_polynomial_simpson_integrator;
    import psi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COEFS = 15;
    localparam int RANDOM_ITEMS = 1050;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_t                  item;
    logic                 done;
    out_t                 result;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    // Own copy of the configuration and the coefficient store of the block
    logic signed [31:0] lo_bound;
    logic signed [31:0] hi_bound;
    logic [15:0]        pairs;
    logic signed [31:0] coef_mem [MAX_COEFS];
    int                 coef_cnt;

    in_t  pending_items [$];
    out_t expected_integrals [$];
    int   send_idle_pct;
    int   errors;

    polynomial_simpson_integrator #(.MAX_DEGREE(MAX_COEFS)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Saturate a wide value to 32 bits, flag any clipping
    function automatic logic signed [31:0] clip32(input logic signed [127:0] v, inout logic ov);
        if (v > 128'sd2147483647)
        begin
            ov = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -128'sd2147483648)
        begin
            ov = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Q16.16 product rounded half up (floor after adding one half)
    function automatic logic signed [127:0] q16_product(input logic signed [31:0] p,
                                                       input logic signed [31:0] q);
        logic signed [127:0] v;
        v = 128'(p) * 128'(q) + 128'sd32768;
        return v >>> 16;
    endfunction

    // Horner evaluation of the stored polynomial at x
    function automatic logic signed [31:0] horner_at(input logic signed [31:0] x,
                                                     input logic signed [31:0] cst,
                                                     inout logic ov);
        logic signed [31:0] acc;
        if (coef_cnt == 0)
            return cst;
        acc = coef_mem[0];
        for (int k = 1; k < coef_cnt; k++)
            acc = clip32(q16_product(acc, x) + 128'(coef_mem[k]), ov);
        return clip32(q16_product(acc, x) + 128'(cst), ov);
    endfunction

    // Full Simpson integration, rounded half away from zero then saturated
    function automatic out_t simpson_integral(input logic signed [31:0] cst);
        out_t r;
        logic ov;
        int unsigned n2;
        logic signed [63:0] span;
        logic signed [31:0] h;
        logic signed [31:0] x;
        logic signed [31:0] f;
        logic signed [127:0] total;
        logic signed [127:0] prod;
        logic [127:0] mag;
        logic [127:0] q;
        logic neg;
        ov = 1'b0;
        total = 0;
        n2 = 2 * ((pairs == 0) ? 1 : pairs);
        span = 64'(hi_bound) - 64'(lo_bound);
        h = 32'(span / $signed(64'(n2)));
        for (int unsigned i = 0; i <= n2; i++)
        begin
            x = (i == n2) ? hi_bound : 32'(64'(lo_bound) + 64'(i) * 64'(h));
            f = horner_at(x, cst, ov);
            if (i == 0 || i == n2)
                total += 128'(f);
            else if (i[0])
                total += 4 * 128'(f);
            else
                total += 2 * 128'(f);
        end
        prod = total * 128'(h);
        neg  = prod < 0;
        mag  = neg ? -prod : prod;
        q    = (mag + 128'd98304) / 128'd196608;
        if (q > 128'h8000_0000 || (!neg && q > 128'h7FFF_FFFF))
        begin
            ov = 1'b1;
            r.integral = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
            r.integral = neg ? -32'(q) : 32'(q);
        r.overflow = ov;
        return r;
    endfunction

    // Predict the block's response to one accepted transaction
    task automatic predict_transaction(input in_t t);
        if (!t.is_constant_term)
        begin
            if (coef_cnt < MAX_COEFS)
            begin
                coef_mem[coef_cnt] = t.coef_value;
                coef_cnt++;
            end
        end
        else
        begin
            expected_integrals = {expected_integrals, simpson_integral(t.coef_value)};
            coef_cnt = 0;
        end
    endtask

    // Driver: hold start while a transaction waits, drop it after acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            in_t nxt;
            logic take;
            take = start && !busy;
            if (take)
            begin
                predict_transaction(item);
                void'(pending_items.pop_front());
            end
            if ((!start || take) && pending_items.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_items[0];
                start <= 1'b1;
                item  <= nxt;
            end
            else if (take)
                start <= 1'b0;
        end
    end

    // Monitor: compare every strobed result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_integrals.size() == 0)
            begin
                $display("%0t unexpected result: integral %h overflow %b",
                         $realtime, result.integral, result.overflow);
                errors++;
            end
            else
            begin
                out_t want;
                want = expected_integrals.pop_front();
                if (result.integral !== want.integral)
                begin
                    $display("%0t integral mismatch: expected %h actual %h",
                             $realtime, want.integral, result.integral);
                    errors++;
                end
                if (result.overflow !== want.overflow)
                begin
                    $display("%0t overflow mismatch: expected %b actual %b",
                             $realtime, want.overflow, result.overflow);
                    errors++;
                end
            end
        end
    end

    // Wait until every queued transaction was taken and all results are in
    task automatic drain();
        while (pending_items.size() > 0 || start)
            @(posedge clk);
        while (expected_integrals.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_LOWER: lo_bound = val;
            CFG_UPPER: hi_bound = val;
            default:   pairs = val[15:0];
        endcase
    endtask

    task automatic set_bounds(input logic [31:0] a, input logic [31:0] b,
                              input logic [15:0] n);
        drain();
        write_reg(CFG_LOWER, a);
        write_reg(CFG_UPPER, b);
        write_reg(CFG_PAIRS, {16'd0, n});
    endtask

    // Queue one polynomial: ncoef ordinary coefficients then the constant term
    task automatic queue_poly(input int ncoef, input int mag_bits);
        in_t t;
        for (int k = 0; k <= ncoef; k++)
        begin
            t.coef_value = $urandom();
            if (mag_bits < 32)
                t.coef_value = $signed(t.coef_value) >>> (32 - mag_bits);
            t.is_constant_term = (k == ncoef);
            pending_items = {pending_items, t};
        end
    endtask

    function automatic logic [31:0] rand_bound();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
            default: return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
        endcase
    endfunction

    initial
    begin
        in_t t;
        int count;
        int target;
        errors        = 0;
        send_idle_pct = 15;
        coef_cnt      = 0;
        lo_bound      = 0;
        hi_bound      = 65536;
        pairs         = 1;
        cfg_write     = 1'b0;
        cfg_index     = CFG_LOWER;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset configuration, constant alone, extremes of coefficients
        t = '{coef_value: 32'sd65536, is_constant_term: 1'b1};
        pending_items = {pending_items, t};
        t = '{coef_value: 32'sh7FFF_FFFF, is_constant_term: 1'b0};
        pending_items = {pending_items, t};
        t = '{coef_value: 32'sh8000_0000, is_constant_term: 1'b1};
        pending_items = {pending_items, t};
        // Too many coefficients: 18 before the constant term
        for (int k = 0; k < 18; k++)
        begin
            t = '{coef_value: 32'(k * 4096 - 30000), is_constant_term: 1'b0};
            pending_items = {pending_items, t};
        end
        t = '{coef_value: 32'sd0, is_constant_term: 1'b1};
        pending_items = {pending_items, t};

        // Zero pair count, reversed bounds, equal bounds, extreme bounds, maximum pair count
        set_bounds(32'sd0, 32'sd131072, 16'd0);
        queue_poly(2, 20);
        set_bounds(32'sd196608, -32'sd65536, 16'd3);
        queue_poly(3, 18);
        set_bounds(32'sd65536, 32'sd65536, 16'd2);
        queue_poly(1, 32);
        set_bounds(32'sh8000_0000, 32'sh7FFF_FFFF, 16'd1);
        queue_poly(1, 32);
        set_bounds(32'sh7FFF_FFFF, 32'sh8000_0000, 16'd2);
        queue_poly(0, 32);
        set_bounds(32'sd0, 32'sd65536, 16'hFFFF);
        queue_poly(0, 20);

        // Random phases: sender idling 15%, then 48%, then none
        count = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 48 : 0;
            target = (ph + 1) * RANDOM_ITEMS / 3;
            while (count < target)
            begin
                set_bounds(rand_bound(), rand_bound(),
                           ($urandom_range(9) == 0) ? 16'($urandom_range(0, 300))
                                                    : 16'($urandom_range(0, 6)));
                for (int p = 0; p < 8 && count < target; p++)
                begin
                    int nc;
                    nc = ($urandom_range(9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 5);
                    queue_poly(nc, ($urandom_range(3) == 0) ? 32 : $urandom_range(12, 22));
                    count += nc + 1;
                end
            end
        end
        drain();
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_integrals.size() == 0)
            $display("[polynomial_simpson_integrator] OK");
        else
            $display("[polynomial_simpson_integrator] ERROR");
        $finish;
    end

    initial
    begin
        #150ms;
        $display("[polynomial_simpson_integrator] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
sv/psi_pkg.sv
sv/psi_divider.sv
sv/psi_datapath.sv
sv/psi_controller.sv
sv/polynomial_simpson_integrator.sv
sv/psi_checker.sv
verif/tb_polynomial_simpson_integrator.sv
